### design/tfwf_pkg.sv
// shared types and constants for the trigger frame window filter
package tfwf_pkg;

  localparam int TRIGGER_COUNT_BITS_DEFAULT = 16;
  localparam int FRAME_NUMBER_BITS_DEFAULT  = 64;

  localparam int FRAME_W     = 64;
  localparam int INDEX_W     = 64;
  localparam int EXPECTED_W  = 16;
  localparam int WINDOW_W    = 32;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 5;

  localparam logic [FRAME_W-1:0] WINDOW_MARGIN = 64'd5;

  // register numbers, at byte address 8 * number
  localparam logic [1:0] REG_EXPECTED_TRIGGERS = 2'd0;
  localparam logic [1:0] REG_FRAMES_IN_WINDOW  = 2'd1;
  localparam logic [1:0] REG_PEDESTAL_FRAME    = 2'd2;

  typedef enum logic [1:0] {
    ST_ACCEPT   = 2'd0,
    ST_PEDESTAL = 2'd1,
    ST_IGNORE   = 2'd2,
    ST_PAST_END = 2'd3
  } status_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_no;
    logic               trigger_seen;
  } frame_item_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] image_index;
    logic               sequence_start;
  } result_item_t;

endpackage

### design/trigger_frame_window_filter.sv
// trigger frame window filter: frame numbers in, status and image index out
//
// One item is accepted per clock unless the output stalls; each passes the
// input register, decision stage and index stage. The trigger count and last
// trigger frame are updated in the decision stage, so each frame sees the state
// left by the frame just before it. The linear index multiply sits alone in the
// index stage. Configuration sits at byte addresses 0, 8 and 16 of a 64-bit APB
// port; the user must write it only while idle, which the block does not enforce.
module trigger_frame_window_filter #(
  parameter int TRIGGER_COUNT_BITS = tfwf_pkg::TRIGGER_COUNT_BITS_DEFAULT,
  parameter int FRAME_NUMBER_BITS  = tfwf_pkg::FRAME_NUMBER_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            frame_valid,
  output logic                            frame_ready,
  input  tfwf_pkg::frame_item_t           frame,
  output logic                            result_valid,
  input  logic                            result_ready,
  output tfwf_pkg::result_item_t          result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tfwf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tfwf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tfwf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tfwf_pkg::*;

  localparam int TCB  = TRIGGER_COUNT_BITS;
  localparam int FNB  = FRAME_NUMBER_BITS;
  localparam int PROD_W = TCB + WINDOW_W;

  typedef struct packed {
    status_t            status;
    logic               use_product;
    logic [INDEX_W-1:0] base;
    logic [TCB-1:0]     count_m1;
    logic [WINDOW_W-1:0] delta;
    logic               sequence_start;
  } decide_t;

  // configuration
  logic [EXPECTED_W-1:0] expected_trigger_count;
  logic [WINDOW_W-1:0]   frames_in_window;
  logic [FRAME_W-1:0]    pedestal_frame;
  logic [1:0]            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_trigger_count <= '0;
      frames_in_window       <= '0;
      pedestal_frame         <= '1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_EXPECTED_TRIGGERS: expected_trigger_count <= pwdata[EXPECTED_W-1:0];
        REG_FRAMES_IN_WINDOW:  frames_in_window <= pwdata[WINDOW_W-1:0];
        REG_PEDESTAL_FRAME:    pedestal_frame <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_EXPECTED_TRIGGERS: prdata = APB_DATA_W'(expected_trigger_count);
      REG_FRAMES_IN_WINDOW:  prdata = APB_DATA_W'(frames_in_window);
      REG_PEDESTAL_FRAME:    prdata = pedestal_frame;
      default:               prdata = '0;
    endcase
  end

  // pipeline control
  logic         in_valid;
  frame_item_t  in_item;
  logic         mid_valid;
  decide_t      mid;
  logic         in_go;
  logic         mid_go;
  logic         mid_free;
  logic         out_free;

  assign out_free    = !result_valid || result_ready;
  assign mid_go      = mid_valid && out_free;
  assign mid_free    = !mid_valid || mid_go;
  assign in_go       = in_valid && mid_free;
  assign frame_ready = !in_valid || in_go;

  // window state
  logic [TCB-1:0] triggers_counted;
  logic [TCB-1:0] triggers_counted_next;
  logic [FNB-1:0] last_trigger_frame;
  logic [FNB-1:0] last_trigger_frame_next;

  logic [FNB-1:0] fr;
  logic [FNB-1:0] fm1;
  logic [FNB-1:0] delta;
  logic [FNB-1:0] delta_after;
  logic           neg;
  logic           opens;
  logic [31:0]    count_ext;
  logic [31:0]    count_after_ext;
  logic [31:0]    expected_ext;
  logic [FRAME_W-1:0] delta_wide;
  logic [FRAME_W-1:0] window_wide;
  decide_t        mid_next;

  assign fr           = in_item.frame_no[FNB-1:0];
  assign fm1          = fr - FNB'(1);
  assign delta        = fm1 - last_trigger_frame;
  assign neg          = delta[FNB-1];
  assign count_ext    = 32'(triggers_counted);
  assign expected_ext = 32'(expected_trigger_count);
  assign window_wide  = FRAME_W'(frames_in_window);

  // a trigger opens a window once the previous one has fully gone by
  // pedestal and zero frames leave the window state alone
  assign opens = in_item.trigger_seen && (fr != pedestal_frame[FNB-1:0]) && (fr != '0) &&
                 (count_ext < expected_ext) &&
                 (triggers_counted != '1) &&
                 ((triggers_counted == '0) ||
                  (!neg && (FRAME_W'(delta) > window_wide)));

  assign delta_after     = opens ? '0 : delta;
  assign delta_wide      = FRAME_W'(delta_after);
  assign triggers_counted_next = opens ? triggers_counted + TCB'(1) : triggers_counted;
  assign count_after_ext = 32'(triggers_counted_next);

  always_comb begin
    mid_next                = '0;
    mid_next.status         = ST_IGNORE;
    mid_next.count_m1       = triggers_counted_next - TCB'(1);
    mid_next.delta          = delta_wide[WINDOW_W-1:0];
    last_trigger_frame_next = last_trigger_frame;
    if (fr == pedestal_frame[FNB-1:0]) begin
      mid_next.status = ST_PEDESTAL;
      mid_next.base   = INDEX_W'(fr);
    end else if (fr == '0) begin
      mid_next.status = ST_IGNORE;
    end else if (expected_trigger_count == '0) begin
      if (FRAME_W'(fm1) >= window_wide) begin
        mid_next.status = ST_PAST_END;
      end else begin
        mid_next.status = ST_ACCEPT;
        mid_next.base   = INDEX_W'(fm1);
      end
    end else begin
      mid_next.sequence_start = opens;
      if (opens) begin
        last_trigger_frame_next = fm1;
      end
      if ((count_after_ext == expected_ext) && !delta_after[FNB-1] &&
          (delta_wide >= window_wide + WINDOW_MARGIN)) begin
        mid_next.status = ST_PAST_END;
      end else if ((triggers_counted_next != '0) && !delta_after[FNB-1] &&
                   (delta_wide < window_wide)) begin
        mid_next.status      = ST_ACCEPT;
        mid_next.use_product = 1'b1;
      end else begin
        mid_next.status = ST_IGNORE;
      end
    end
  end

  // index stage: window number times window length plus offset, or the decided base
  logic [PROD_W-1:0]  product;
  logic [INDEX_W-1:0] index_next;

  assign product    = PROD_W'(mid.count_m1) * PROD_W'(frames_in_window);
  assign index_next = mid.use_product ?
                      INDEX_W'(product) + INDEX_W'(mid.delta) : mid.base;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid           <= 1'b0;
      mid_valid          <= 1'b0;
      result_valid       <= 1'b0;
      triggers_counted   <= '0;
      last_trigger_frame <= '0;
    end else begin
      if (frame_valid && frame_ready) begin
        in_valid <= 1'b1;
      end else if (in_go) begin
        in_valid <= 1'b0;
      end
      if (in_go) begin
        mid_valid <= 1'b1;
      end else if (mid_go) begin
        mid_valid <= 1'b0;
      end
      if (mid_go) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      // state only moves when the item enters the decision stage
      if (in_go) begin
        triggers_counted   <= triggers_counted_next;
        last_trigger_frame <= last_trigger_frame_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      in_item <= frame;
    end
    if (in_go) begin
      mid <= mid_next;
    end
    if (mid_go) begin
      result.status         <= mid.status;
      result.image_index    <= index_next;
      result.sequence_start <= mid.sequence_start;
    end
  end

endmodule
